// ===== hw/rtl/ble_pkg.sv =====
// Shared types, widths and codes for the bounded ordered list engine.
package ble_pkg;

  // Store size and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the command and response beats.
  localparam int CMD_W   = 3;
  localparam int VAL_W   = 32;
  localparam int INDEX_W = 6;
  localparam int ST_W    = 3;
  localparam int POS_W   = 6;
  localparam int LEN_W   = 7;

  // Width wide enough to compare a command index against the element count.
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef logic [CMD_W-1:0] cmd_code_t;
  typedef logic [ST_W-1:0]  status_t;

  // Command codes.
  localparam cmd_code_t CMD_PUSH_FRONT   = 3'd0;
  localparam cmd_code_t CMD_PUSH_BACK    = 3'd1;
  localparam cmd_code_t CMD_POP_FRONT    = 3'd2;
  localparam cmd_code_t CMD_POP_BACK     = 3'd3;
  localparam cmd_code_t CMD_INSERT_AT    = 3'd4;
  localparam cmd_code_t CMD_REMOVE_AT    = 3'd5;
  localparam cmd_code_t CMD_REMOVE_VALUE = 3'd6;
  localparam cmd_code_t CMD_FIND         = 3'd7;

  // Status codes.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_PAST_END  = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  // Shift operations broadcast to the cell row.
  typedef logic [1:0] op_t;
  localparam op_t OP_HOLD  = 2'd0;
  localparam op_t OP_OPEN  = 2'd1;
  localparam op_t OP_CLOSE = 2'd2;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] key;
    logic                    start;
    logic                    walk;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/ble_cmd_if.sv =====
// Command channel: valid/ready handshake with the command payload.
interface ble_cmd_if import ble_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [VAL_W-1:0]  value;
  logic [INDEX_W-1:0]       index;

  modport source (output valid, output command, output value, output index, input ready);
  modport sink   (input valid, input command, input value, input index, output ready);
endinterface

// ===== hw/rtl/ble_rsp_if.sv =====
// Response channel: valid/ready handshake with the result payload.
interface ble_rsp_if import ble_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] position;
  logic [LEN_W-1:0] length;

  modport source (output valid, output status, output position, output length, input ready);
  modport sink   (input valid, input status, input position, input length, output ready);
endinterface

// ===== hw/rtl/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: sequencer plus a row of element cells.
//
//   Channel  Role  Beat contents
//   cmd      sink  command (3b), value (32b signed), index (6b)
//   rsp      src   status (3b), position (6b), length (7b)
//
// Insert and remove commands shift the whole cell row in the cycle the command beat is taken;
// the result then passes through the DONE state and the output register before the response
// beat is offered. Remove-value and find walk a token down the row one cell per cycle and stop
// at the first match or at the last element. One command is worked on at a time; a new command
// is taken while a finished result still waits in the output register, and a stalled response
// beat holds the next result back. Reset (rst, synchronous) empties the list at once; element
// contents are left as they are.
module bounded_ordered_list_engine import ble_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ble_cmd_if.sink   cmd,
  ble_rsp_if.source rsp
);

  cell_ctl_t               ctl;
  logic [CAPACITY-1:0]     hits;
  logic [CAPACITY-1:0]     toks;
  logic signed [VAL_W-1:0] cell_data [CAPACITY];

  // Command decode, count and result handling.
  ble_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .rsp  (rsp),
    .ctl  (ctl),
    .hits (hits)
  );

  // Row of cells, each linked to its left and right neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_data;
    logic signed [VAL_W-1:0] right_data;
    logic                    left_tok;

    if (g == 0) begin : g_first
      assign left_data = '0;
      assign left_tok  = 1'b0;
    end else begin : g_inner_left
      assign left_data = cell_data[g-1];
      assign left_tok  = toks[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_right
      assign right_data = cell_data[g+1];
    end

    ble_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .slot       (IDX_W'(g)),
      .left_data  (left_data),
      .right_data (right_data),
      .left_tok   (left_tok),
      .data       (cell_data[g]),
      .tok        (toks[g]),
      .hit        (hits[g])
    );
  end

endmodule

// ===== hw/rtl/ble_cell.sv =====
// One list slot: holds an element, shifts with its neighbors and takes part in the search walk.
module ble_cell import ble_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctl_t               ctl,
  input  logic [IDX_W-1:0]        slot,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  input  logic                    left_tok,
  output logic signed [VAL_W-1:0] data,
  output logic                    tok,
  output logic                    hit
);

  // Element register: open a gap by taking from the left, close one by taking from the right.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_OPEN: begin
        if (slot > ctl.pos) begin
          data <= left_data;
        end else if (slot == ctl.pos) begin
          data <= ctl.val;
        end
      end
      OP_CLOSE: begin
        if (slot >= ctl.pos) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  // Search token: enters at the front slot and moves one slot per cycle while the walk runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.start) begin
      tok <= (slot == '0);
    end else if (ctl.walk) begin
      tok <= left_tok;
    end else begin
      tok <= 1'b0;
    end
  end

  // The slot holding the token reports whether its element matches the key.
  assign hit = tok && (data == ctl.key);

endmodule

// ===== hw/rtl/ble_ctrl.sv =====
// Command sequencer: decodes commands, keeps the count, runs the search walk and the result register.
module ble_ctrl import ble_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ble_cmd_if.sink             cmd,
  ble_rsp_if.source           rsp,
  output cell_ctl_t           ctl,
  input  logic [CAPACITY-1:0] hits
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]              state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic signed [VAL_W-1:0] key, key_next;
  logic                    remove, remove_next;
  logic [IDX_W-1:0]        step, step_next;
  status_t                 res_status, res_status_next;
  logic [IDX_W-1:0]        res_pos, res_pos_next;

  logic             out_valid;
  status_t          out_status;
  logic [POS_W-1:0] out_pos;
  logic [LEN_W-1:0] out_len;
  logic             out_load;

  logic             accept;
  logic [CMP_W-1:0] idx_cmp;
  logic [CMP_W-1:0] cnt_cmp;
  logic             is_full;
  logic             is_empty;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign idx_cmp   = CMP_W'(cmd.index);
  assign cnt_cmp   = CMP_W'(count);
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign is_empty  = (count == '0);
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  // Next-state logic for the sequencer and the broadcast to the cells.
  always_comb begin
    state_next      = state;
    count_next      = count;
    key_next        = key;
    remove_next     = remove;
    step_next       = step;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    ctl.op          = OP_HOLD;
    ctl.pos         = '0;
    ctl.val         = cmd.value;
    ctl.key         = key;
    ctl.start       = 1'b0;
    ctl.walk        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_pos_next    = '0;
          res_status_next = ST_OK;
          state_next      = S_DONE;
          unique case (cmd.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
              if (is_full) begin
                res_status_next = ST_FULL;
              end else begin
                ctl.op = OP_OPEN;
                if (cmd.command == CMD_PUSH_FRONT) begin
                  ctl.pos = '0;
                end else if (cmd.command == CMD_PUSH_BACK || idx_cmp > cnt_cmp) begin
                  ctl.pos = IDX_W'(count);
                end else begin
                  ctl.pos = IDX_W'(cmd.index);
                end
                count_next = count + CNT_W'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else if (cmd.command == CMD_REMOVE_AT && idx_cmp >= cnt_cmp) begin
                res_status_next = ST_PAST_END;
              end else begin
                ctl.op = OP_CLOSE;
                if (cmd.command == CMD_POP_FRONT) begin
                  ctl.pos = '0;
                end else if (cmd.command == CMD_POP_BACK) begin
                  ctl.pos = IDX_W'(count - CNT_W'(1));
                end else begin
                  ctl.pos = IDX_W'(cmd.index);
                end
                res_pos_next = ctl.pos;
                count_next   = count - CNT_W'(1);
              end
            end
            CMD_REMOVE_VALUE, CMD_FIND: begin
              if (is_empty) begin
                res_status_next = (cmd.command == CMD_REMOVE_VALUE) ? ST_EMPTY : ST_NOT_FOUND;
              end else begin
                ctl.start   = 1'b1;
                key_next    = cmd.value;
                remove_next = (cmd.command == CMD_REMOVE_VALUE);
                step_next   = '0;
                state_next  = S_SEARCH;
              end
            end
          endcase
        end
      end
      S_SEARCH: begin
        // The token sits at slot "step"; stop at the first hit or at the last element.
        if (|hits) begin
          res_status_next = ST_OK;
          res_pos_next    = step;
          if (remove) begin
            ctl.op     = OP_CLOSE;
            ctl.pos    = step;
            count_next = count - CNT_W'(1);
          end
          state_next = S_DONE;
        end else if (CNT_W'(step) + CNT_W'(1) == count) begin
          res_status_next = ST_NOT_FOUND;
          res_pos_next    = '0;
          state_next      = S_DONE;
        end else begin
          ctl.walk  = 1'b1;
          step_next = step + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    key        <= key_next;
    remove     <= remove_next;
    step       <= step_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
  end

  // Output register: holds a finished result until the response beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_status <= res_status;
      out_pos    <= POS_W'(res_pos);
      out_len    <= LEN_W'(count);
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_pos;
  assign rsp.length   = out_len;

endmodule

// ===== hw/rtl/ble_checker.sv =====
// Port-level checks for the bounded ordered list engine, bound to the top level.
module ble_checker import ble_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [ST_W-1:0]  rsp_status,
  input logic [POS_W-1:0] rsp_position,
  input logic [LEN_W-1:0] rsp_length
);

  // A response beat that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped before it was taken");

  // A full flag only comes with a store at capacity.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_length == LEN_W'(CAPACITY))
    else $error("full status with a length below capacity");

  // An empty flag only comes with an empty store.
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_length == '0)
    else $error("empty status with a nonzero length");

  // A failed command reports position zero.
  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_position == '0)
    else $error("nonzero position on a failed command");

  // No response is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response offered right after reset");

endmodule

bind bounded_ordered_list_engine ble_checker u_ble_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.position),
  .rsp_length   (rsp.length)
);

// ===== tb/bounded_ordered_list_engine_check.sv =====
`timescale 1ns / 1ps
// Checker for the bounded ordered list engine: watches both channels, predicts and compares.
module bounded_ordered_list_engine_check import ble_pkg::*; (
  input  logic clk,
  input  logic rst,
  ble_cmd_if   cmd,
  ble_rsp_if   rsp,
  output int   errors,
  output int   pending
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] length;
  } list_result_t;

  // Results still owed by the engine, oldest first.
  list_result_t            result_queue[$];

  // Shadow copy of the ordered list.
  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int                      shadow_len;
  int                      mismatch_count;

  // Position of the first element equal to v, or the length when there is none.
  function automatic int locate(logic signed [VAL_W-1:0] v);
    int i;
    for (i = 0; i < shadow_len; i++) begin
      if (shadow_list[i] == v) return i;
    end
    return shadow_len;
  endfunction

  // Applies one command to the shadow list and returns the result it should produce.
  function automatic list_result_t apply_command(cmd_code_t op, logic signed [VAL_W-1:0] v,
                                                 logic [INDEX_W-1:0] ix);
    list_result_t r;
    int           at;
    int           i;
    r.status = ST_OK;
    at       = 0;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (op == CMD_PUSH_FRONT) at = 0;
          else if (op == CMD_PUSH_BACK || int'(ix) > shadow_len) at = shadow_len;
          else at = int'(ix);
          for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = v;
          shadow_len++;
        end
        // Insertions always report position zero.
        at = 0;
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT, CMD_REMOVE_VALUE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == CMD_POP_FRONT) begin
            at = 0;
          end else if (op == CMD_POP_BACK) begin
            at = shadow_len - 1;
          end else if (op == CMD_REMOVE_AT) begin
            at = int'(ix);
            if (at >= shadow_len) r.status = ST_PAST_END;
          end else begin
            at = locate(v);
            if (at >= shadow_len) r.status = ST_NOT_FOUND;
          end
          if (r.status == ST_OK) begin
            for (i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
            shadow_len--;
          end else begin
            at = 0;
          end
        end
      end
      default: begin
        // Find leaves the list as it is.
        at = locate(v);
        if (at >= shadow_len) begin
          r.status = ST_NOT_FOUND;
          at       = 0;
        end
      end
    endcase
    r.position = POS_W'(at);
    r.length   = LEN_W'(shadow_len);
    return r;
  endfunction

  // Response beats are checked before the command beat of the same edge is predicted.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      result_queue.delete();
      shadow_len     = 0;
      mismatch_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (result_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: response beat with nothing expected: status %0d position %0d length %0d",
                     $realtime, rsp.status, rsp.position, rsp.length);
        end else begin
          want = result_queue.pop_front();
          if (rsp.status !== want.status || rsp.position !== want.position ||
              rsp.length !== want.length) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: response mismatch: expected status %0d position %0d length %0d, got status %0d position %0d length %0d",
                       $realtime, want.status, want.position, want.length,
                       rsp.status, rsp.position, rsp.length);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        result_queue.push_back(apply_command(cmd.command, cmd.value, cmd.index));
    end
    errors  <= mismatch_count;
    pending <= result_queue.size();
  end

endmodule

// ===== tb/bounded_ordered_list_engine_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the bounded ordered list engine: clock, reset, stimulus and verdict.
module bounded_ordered_list_engine_test;
  import ble_pkg::*;

  localparam int MAX_GAP      = 8;
  localparam int STALL_LIMIT  = 10 * (CAPACITY + 2 * MAX_GAP + 4);
  localparam int PHASE_ITEMS  = 95;
  localparam int PHASE_COUNT  = 7;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [INDEX_W-1:0]      IDX_TOP = '1;

  typedef enum {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;
  typedef enum {K_ADD, K_DROP, K_LOOK} kind_t;

  logic clk;
  logic rst;
  bit   no_idle;
  int   fail_count;
  int   pending_count;
  int   quiet_cycles;

  ble_cmd_if cmd_ch();
  ble_rsp_if rsp_ch();

  bounded_ordered_list_engine DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  bounded_ordered_list_engine_check u_check (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .errors  (fail_count),
    .pending (pending_count)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sends one command beat after a random gap; returns at the edge that accepts it.
  task automatic send_command(cmd_code_t op, logic signed [VAL_W-1:0] v,
                              logic [INDEX_W-1:0] ix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.value   <= v;
    cmd_ch.index   <= ix;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Response side: stalls a random number of cycles before taking each beat.
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bounded_ordered_list_engine_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    phase_t                  mode;
    kind_t                   kind;
    cmd_code_t               op;
    logic signed [VAL_W-1:0] v;
    logic [INDEX_W-1:0]      ix;
    int                      pick;
    int                      ph;
    int                      n;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_PUSH_FRONT;
    cmd_ch.value   <= '0;
    cmd_ch.index   <= '0;
    no_idle        = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: the removal and search commands and an insert on an empty list, then edge positions and extreme values.
    send_command(CMD_FIND, '0, '0);
    send_command(CMD_POP_FRONT, '0, '0);
    send_command(CMD_POP_BACK, '0, '0);
    send_command(CMD_REMOVE_AT, '0, '0);
    send_command(CMD_REMOVE_VALUE, 5, '0);
    send_command(CMD_INSERT_AT, VAL_MIN, IDX_TOP);
    send_command(CMD_PUSH_BACK, VAL_MAX, '0);
    send_command(CMD_PUSH_FRONT, -1, '0);
    send_command(CMD_INSERT_AT, 0, INDEX_W'(1));
    send_command(CMD_INSERT_AT, 7, INDEX_W'(4));
    send_command(CMD_FIND, VAL_MAX, '0);
    send_command(CMD_FIND, 123, '0);
    send_command(CMD_PUSH_BACK, -1, IDX_TOP);
    send_command(CMD_FIND, -1, '0);
    send_command(CMD_REMOVE_VALUE, -1, '0);
    send_command(CMD_FIND, -1, '0);
    send_command(CMD_REMOVE_VALUE, 99, '0);
    send_command(CMD_REMOVE_AT, '0, IDX_TOP);
    send_command(CMD_REMOVE_AT, '0, INDEX_W'(4));
    send_command(CMD_REMOVE_AT, '0, INDEX_W'(1));
    send_command(CMD_POP_BACK, '0, '0);
    send_command(CMD_POP_FRONT, '0, '0);
    send_command(CMD_POP_FRONT, '0, '0);
    send_command(CMD_REMOVE_VALUE, VAL_MIN, '0);

    // Random phases: growth to a full list, mixed traffic, and draining to empty.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0, 3, 5: mode = PH_GROW;
        2, 6:    mode = PH_SHRINK;
        default: mode = PH_MIXED;
      endcase
      no_idle = (ph % 3 == 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          PH_GROW:   kind = (pick < 85) ? K_ADD : ((pick < 93) ? K_DROP : K_LOOK);
          PH_SHRINK: kind = (pick < 85) ? K_DROP : ((pick < 93) ? K_ADD : K_LOOK);
          default:   kind = (pick < 38) ? K_ADD : ((pick < 72) ? K_DROP : K_LOOK);
        endcase
        case (kind)
          K_ADD: begin
            case ($urandom_range(0, 2))
              0:       op = CMD_PUSH_FRONT;
              1:       op = CMD_PUSH_BACK;
              default: op = CMD_INSERT_AT;
            endcase
          end
          K_DROP: begin
            case ($urandom_range(0, 3))
              0:       op = CMD_POP_FRONT;
              1:       op = CMD_POP_BACK;
              2:       op = CMD_REMOVE_AT;
              default: op = CMD_REMOVE_VALUE;
            endcase
          end
          default: begin
            op = ($urandom_range(0, 3) == 0) ? cmd_code_t'($urandom_range(0, 7)) : CMD_FIND;
          end
        endcase
        // A small pool of values makes duplicates and search hits common.
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            v = $urandom_range(0, 11);
            v = v - 6;
          end
          5:       v = VAL_MIN;
          6:       v = VAL_MAX;
          7:       v = -1;
          default: v = $urandom;
        endcase
        ix = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1))
                                  : INDEX_W'($urandom_range(0, 7));
        send_command(op, v, ix);
      end
    end
    cmd_ch.valid <= 1'b0;

    // Drain the outstanding results, then give the engine time for a stray beat.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (CAPACITY + 2 * MAX_GAP + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_ordered_list_engine_test: done, clean");
    end else begin
      $display("bounded_ordered_list_engine_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ble_pkg.sv
hw/rtl/ble_cmd_if.sv
hw/rtl/ble_rsp_if.sv
hw/rtl/ble_cell.sv
hw/rtl/ble_ctrl.sv
hw/rtl/bounded_ordered_list_engine.sv
hw/rtl/ble_checker.sv
tb/bounded_ordered_list_engine_check.sv
tb/bounded_ordered_list_engine_test.sv
